[sv/four_function_calculator_entry_assert.svh]
// Assertion macros shared by the calculator entry RTL.
`ifndef FOUR_FUNCTION_CALCULATOR_ENTRY_ASSERT_SVH
`define FOUR_FUNCTION_CALCULATOR_ENTRY_ASSERT_SVH

// Checked only outside reset.
`define FFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FFC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ffc_pkg.sv]
// Shared constants, types and helpers for the calculator entry block.
package ffc_pkg;

	localparam int LINE_LEN = 16;
	localparam int OPB      = 32;
	localparam int IDX_W    = $clog2(LINE_LEN) + 1;
	localparam int CNT_W    = $clog2(OPB);

	// x / 10 == (x * RECIP10) >> RECIP10_SH, exact over the full 32-bit operand range
	localparam int             RECIP10_SH = OPB + 3;
	localparam logic [OPB-1:0] RECIP10    =
		OPB'((({{(OPB+3){1'b0}}, 1'b1} << (OPB + 3)) / 10) + 1);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_TIMES = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NONE  = 8'h00;

	localparam logic [4:0] NO_KEY       = 5'd16;
	localparam logic [3:0] KEY_DIGIT_LIM = 4'd10;
	localparam logic [3:0] KEY_MINUS    = 4'd11;
	localparam logic [3:0] KEY_EQUALS   = 4'd14;
	localparam logic [3:0] KEY_BKSP     = 4'd15;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MAC10,
		ALU_MUL,
		ALU_DIV,
		ALU_DIV10
	} ffc_alu_op_t;

	typedef struct packed {
		logic              start;
		ffc_alu_op_t       op;
		logic [OPB-1:0]    x;
		logic [OPB-1:0]    y;
	} ffc_alu_req_t;

	typedef struct packed {
		logic              done;
		logic [OPB-1:0]    res;
		logic [OPB-1:0]    rem;
	} ffc_alu_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SKIP,
		S_SIGN,
		S_PA,
		S_PA_W,
		S_PB,
		S_PB_W,
		S_CALC,
		S_CALC_W,
		S_CONV_INIT,
		S_CONV,
		S_CONV_W,
		S_SGN_OUT,
		S_APPEND,
		S_EMIT
	} ffc_state_t;

	function automatic logic [7:0] op_char(input logic [1:0] code_lo);
		logic [7:0] c;
		case (code_lo)
			2'b10:   c = CH_PLUS;
			2'b11:   c = CH_MINUS;
			2'b00:   c = CH_TIMES;
			default: c = CH_DIV;
		endcase
		return c;
	endfunction

endpackage

[sv/ffc_key_if.sv]
// Keypad event channel.
interface ffc_key_if;
	logic       valid;
	logic       ready;
	logic       key_pressed;
	logic [3:0] key_code;

	modport source(output valid, key_pressed, key_code, input ready);
	modport sink(input valid, key_pressed, key_code, output ready);
endinterface

[sv/ffc_char_if.sv]
// Display character channel.
interface ffc_char_if;
	logic       valid;
	logic       ready;
	logic [3:0] char_position;
	logic [7:0] char_code;
	logic       last_char;

	modport source(output valid, char_position, char_code, last_char, input ready);
	modport sink(input valid, char_position, char_code, last_char, output ready);
endinterface

[sv/ffc_alu.sv]
// Shared arithmetic unit: add, subtract, times-ten accumulate, shift-add multiply,
// restoring divide, reciprocal divide by ten.
`include "four_function_calculator_entry_assert.svh"
module ffc_alu
	import ffc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  ffc_alu_req_t req,
	output ffc_alu_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	ffc_alu_op_t       op_q;
	logic [OPB-1:0]    acc_q;
	logic [OPB-1:0]    sh_q;
	logic [OPB-1:0]    mp_q;
	logic [OPB:0]      rem_q;
	logic [OPB:0]      trial;
	logic [2*OPB-1:0]  div10_prod;

	assign trial      = {rem_q[OPB-1:0], sh_q[OPB-1]};
	assign div10_prod = {{OPB{1'b0}}, req.x} * {{OPB{1'b0}}, RECIP10};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ALU_ADD;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q  <= req.op;
				cnt_q <= (req.op == ALU_DIV10) ? '0 : CNT_W'(OPB - 1);
				if (req.op == ALU_MUL || req.op == ALU_DIV || req.op == ALU_DIV10) begin
					busy_q <= 1'b1;
				end else begin
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			case (req.op)
				ALU_ADD:   acc_q <= req.x + req.y;
				ALU_SUB:   acc_q <= req.x - req.y;
				ALU_MAC10: acc_q <= (req.x << 3) + (req.x << 1) + req.y;
				ALU_MUL: begin
					acc_q <= '0;
					sh_q  <= req.x;
					mp_q  <= req.y;
				end
				// quotient now, remainder on the following cycle
				ALU_DIV10: begin
					acc_q <= OPB'(div10_prod >> RECIP10_SH);
					sh_q  <= req.x;
				end
				default: begin
					rem_q <= '0;
					sh_q  <= req.x;
					mp_q  <= req.y;
				end
			endcase
		end else if (busy_q) begin
			if (op_q == ALU_MUL) begin
				if (mp_q[0]) begin
					acc_q <= acc_q + sh_q;
				end
				sh_q <= sh_q << 1;
				mp_q <= mp_q >> 1;
			end else if (op_q == ALU_DIV10) begin
				rem_q <= {1'b0, sh_q - ((acc_q << 3) + (acc_q << 1))};
			end else begin
				if (trial >= {1'b0, mp_q}) begin
					rem_q <= trial - {1'b0, mp_q};
					sh_q  <= {sh_q[OPB-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					sh_q  <= {sh_q[OPB-2:0], 1'b0};
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = (op_q == ALU_DIV) ? sh_q : acc_q;
	assign rsp.rem  = rem_q[OPB-1:0];

	`FFC_ASSERT(a_no_start_busy, req.start |-> !busy_q, "ALU started while busy")
	`FFC_ASSERT(a_done_ends_busy, done_q |-> !busy_q, "ALU done while still iterating")
	`FFC_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !busy_q, "ALU busy in reset")

endmodule

[sv/four_function_calculator_entry.sv]
// Keypad entry and display line of a four-function calculator; 16 characters per handled key.
// A digit, backspace or plain key goes straight from idle to emitting its 16 transfers.
// Evaluation parses each operand character through the ALU, runs the operation (times and divide
// iterate), then converts the result digit by digit. One key at a time; not ready meanwhile.
// Reset clears the line to spaces, drops the pending operator and forgets the last key.
`include "four_function_calculator_entry_assert.svh"
module four_function_calculator_entry
	import ffc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ffc_key_if.sink    key,
	ffc_char_if.source disp
);

	ffc_state_t        state_q, state_d;
	logic [7:0]        line_q [LINE_LEN];
	logic [7:0]        pend_q;
	logic [7:0]        opnew_q;
	logic [4:0]        prev_q;
	logic              jeval_q;
	logic              append_q;
	logic              neg_q;
	logic [IDX_W-1:0]  idx_q;
	logic [OPB-1:0]    a_q;
	logic [OPB-1:0]    b_q;
	logic [OPB-1:0]    r_q;
	logic [7:0]        opc_q;

	ffc_alu_req_t      alu_req;
	ffc_alu_rsp_t      alu_rsp;

	logic [7:0]        cur;
	logic              cur_digit;
	logic              in_range;
	logic              acc;
	logic              k_digit, k_op, dig_block, press_new, handled;
	logic              op_minus_sign, op_append, op_eval, eq_eval, start_eval;
	logic [7:0]        last_col;
	logic [OPB-1:0]    r_mag;

	function automatic logic [OPB-1:0] mag(input logic [OPB-1:0] v);
		return v[OPB-1] ? (~v + 1'b1) : v;
	endfunction

	ffc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	assign in_range  = idx_q < IDX_W'(LINE_LEN);
	assign cur       = in_range ? line_q[idx_q[IDX_W-2:0]] : CH_NONE;
	assign cur_digit = (cur >= CH_ZERO) && (cur <= CH_NINE);
	assign last_col  = line_q[LINE_LEN-1];
	assign r_mag     = mag(r_q);

	assign acc           = key.valid && key.ready;
	assign k_digit       = key.key_code < KEY_DIGIT_LIM;
	assign k_op          = !k_digit && key.key_code != KEY_EQUALS && key.key_code != KEY_BKSP;
	assign dig_block     = line_q[0] != CH_SPACE
		|| (line_q[LINE_LEN-7] != CH_SPACE && pend_q == CH_SPACE);
	assign press_new     = key.key_pressed && {1'b0, key.key_code} != prev_q;
	assign handled       = press_new && !(k_digit && dig_block);
	assign op_minus_sign = last_col == CH_SPACE && key.key_code == KEY_MINUS;
	assign op_append     = !op_minus_sign && last_col != pend_q && last_col != CH_MINUS;
	assign op_eval       = op_append && pend_q != CH_SPACE;
	assign eq_eval       = key.key_code == KEY_EQUALS && pend_q != CH_SPACE;
	assign start_eval    = eq_eval || (k_op && op_eval);

	assign disp.char_position = 4'(idx_q);
	assign disp.char_code     = line_q[idx_q[IDX_W-2:0]];
	assign disp.last_char     = idx_q == IDX_W'(LINE_LEN - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		key.ready  = 1'b0;
		disp.valid = 1'b0;
		alu_req    = '0;
		case (state_q)
			S_IDLE: begin
				key.ready = 1'b1;
				if (acc && handled) begin
					state_d = start_eval ? S_SKIP : S_EMIT;
				end
			end
			S_SKIP: begin
				if (cur != CH_SPACE) begin
					state_d = S_SIGN;
				end
			end
			S_SIGN: state_d = S_PA;
			S_PA: begin
				if (cur_digit) begin
					alu_req.start = 1'b1;
					alu_req.op    = ALU_MAC10;
					alu_req.x     = a_q;
					alu_req.y     = OPB'(cur[3:0]);
					state_d       = S_PA_W;
				end else begin
					state_d = S_PB;
				end
			end
			S_PA_W: if (alu_rsp.done) state_d = S_PA;
			S_PB: begin
				if (cur_digit) begin
					alu_req.start = 1'b1;
					alu_req.op    = ALU_MAC10;
					alu_req.x     = b_q;
					alu_req.y     = OPB'(cur[3:0]);
					state_d       = S_PB_W;
				end else begin
					state_d = S_CALC;
				end
			end
			S_PB_W: if (alu_rsp.done) state_d = S_PB;
			S_CALC: begin
				alu_req.x = a_q;
				alu_req.y = b_q;
				state_d   = S_CALC_W;
				case (opc_q)
					CH_PLUS:  begin alu_req.start = 1'b1; alu_req.op = ALU_ADD; end
					CH_MINUS: begin alu_req.start = 1'b1; alu_req.op = ALU_SUB; end
					CH_TIMES: begin alu_req.start = 1'b1; alu_req.op = ALU_MUL; end
					CH_DIV: begin
						if (b_q != '0) begin
							alu_req.start = 1'b1;
							alu_req.op    = ALU_DIV;
							alu_req.x     = mag(a_q);
							alu_req.y     = mag(b_q);
						end else begin
							state_d = S_CONV_INIT;
						end
					end
					default: state_d = S_CONV_INIT;
				endcase
			end
			S_CALC_W: if (alu_rsp.done) state_d = S_CONV_INIT;
			S_CONV_INIT: state_d = (r_mag == '0) ? S_SGN_OUT : S_CONV;
			S_CONV: begin
				if (a_q != '0 && in_range) begin
					alu_req.start = 1'b1;
					alu_req.op    = ALU_DIV10;
					alu_req.x     = a_q;
					state_d       = S_CONV_W;
				end else begin
					state_d = S_SGN_OUT;
				end
			end
			S_CONV_W:  if (alu_rsp.done) state_d = S_CONV;
			S_SGN_OUT: state_d = S_APPEND;
			S_APPEND:  state_d = S_EMIT;
			S_EMIT: begin
				disp.valid = 1'b1;
				if (disp.ready && disp.last_char) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LINE_LEN; k++) line_q[k] <= CH_SPACE;
			pend_q   <= CH_SPACE;
			prev_q   <= NO_KEY;
			jeval_q  <= 1'b0;
			append_q <= 1'b0;
			opnew_q  <= CH_SPACE;
			idx_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc && !key.key_pressed) begin
						prev_q <= NO_KEY;
					end else if (acc && handled) begin
						prev_q   <= {1'b0, key.key_code};
						jeval_q  <= key.key_code == KEY_EQUALS;
						idx_q    <= '0;
						append_q <= 1'b0;
						if (k_digit) begin
							for (int k = 0; k < LINE_LEN - 1; k++) begin
								line_q[k] <= jeval_q ? CH_SPACE : line_q[k+1];
							end
							line_q[LINE_LEN-1] <= CH_ZERO | {4'h0, key.key_code};
						end else if (key.key_code == KEY_BKSP) begin
							if (pend_q != CH_SPACE && last_col == pend_q) pend_q <= CH_SPACE;
							for (int k = 1; k < LINE_LEN; k++) line_q[k] <= line_q[k-1];
						end else if (key.key_code == KEY_EQUALS) begin
							pend_q <= CH_SPACE;
						end else if (op_minus_sign) begin
							line_q[LINE_LEN-1] <= CH_MINUS;
						end else if (op_append) begin
							pend_q  <= op_char(key.key_code[1:0]);
							opnew_q <= op_char(key.key_code[1:0]);
							if (op_eval) begin
								append_q <= 1'b1;
							end else begin
								for (int k = 0; k < LINE_LEN - 1; k++) line_q[k] <= line_q[k+1];
								line_q[LINE_LEN-1] <= op_char(key.key_code[1:0]);
							end
						end
					end
				end
				S_SKIP: if (cur == CH_SPACE) idx_q <= idx_q + 1'b1;
				S_SIGN: if (cur == CH_MINUS) idx_q <= idx_q + 1'b1;
				S_PA:   if (!cur_digit) idx_q <= idx_q + 1'b1;
				S_PA_W: if (alu_rsp.done) idx_q <= idx_q + 1'b1;
				S_PB_W: if (alu_rsp.done) idx_q <= idx_q + 1'b1;
				S_CONV_INIT: begin
					for (int k = 0; k < LINE_LEN - 1; k++) line_q[k] <= CH_SPACE;
					if (r_mag == '0) begin
						line_q[LINE_LEN-1] <= CH_ZERO;
						idx_q              <= IDX_W'(LINE_LEN - 2);
					end else begin
						idx_q <= IDX_W'(LINE_LEN - 1);
					end
				end
				S_CONV_W: begin
					if (alu_rsp.done) begin
						line_q[idx_q[IDX_W-2:0]] <= CH_ZERO | {4'h0, alu_rsp.rem[3:0]};
						idx_q                    <= idx_q - 1'b1;
					end
				end
				S_SGN_OUT: begin
					if (neg_q && in_range) line_q[idx_q[IDX_W-2:0]] <= CH_MINUS;
				end
				S_APPEND: begin
					idx_q <= '0;
					if (append_q) begin
						for (int k = 0; k < LINE_LEN - 1; k++) line_q[k] <= line_q[k+1];
						line_q[LINE_LEN-1] <= opnew_q;
					end
				end
				S_EMIT: if (disp.ready) idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Operand and result datapath; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q   <= '0;
				b_q   <= '0;
				neg_q <= 1'b0;
			end
			S_SIGN: if (cur == CH_MINUS) neg_q <= 1'b1;
			S_PA: begin
				if (!cur_digit) begin
					if (neg_q) a_q <= ~a_q + 1'b1;
					opc_q <= cur;
				end
			end
			S_PA_W: if (alu_rsp.done) a_q <= alu_rsp.res;
			S_PB_W: if (alu_rsp.done) b_q <= alu_rsp.res;
			S_CALC: r_q <= '0;
			S_CALC_W: begin
				if (alu_rsp.done) begin
					if (opc_q == CH_DIV && (a_q[OPB-1] ^ b_q[OPB-1])) begin
						r_q <= ~alu_rsp.res + 1'b1;
					end else begin
						r_q <= alu_rsp.res;
					end
				end
			end
			S_CONV_INIT: begin
				neg_q <= r_q[OPB-1];
				a_q   <= r_mag;
			end
			S_CONV_W: if (alu_rsp.done) a_q <= alu_rsp.res;
			default: ;
		endcase
	end

	`FFC_ASSERT(a_ready_no_emit, key.ready |-> !disp.valid, "ready while emitting")
	`FFC_ASSERT(a_release_clears, acc && !key.key_pressed |=> prev_q == NO_KEY,
		"key release not recorded")
	`FFC_ASSERT(a_alu_done_waited, alu_rsp.done |-> (state_q == S_PA_W || state_q == S_PB_W
		|| state_q == S_CALC_W || state_q == S_CONV_W), "ALU result with nobody waiting")

endmodule

[sim/tb_four_function_calculator_entry.sv]
// Self-checking testbench for the calculator entry block: keypad transfers in, display line out.
module tb_four_function_calculator_entry;
	import ffc_pkg::*;

	typedef struct {
		logic       pressed;
		logic [3:0] code;
		bit         drain;
	} key_evt_t;

	typedef struct {
		logic [3:0] pos;
		logic [7:0] ch;
		logic       last;
	} disp_char_t;

	localparam logic [3:0] KEY_PLUS  = 4'd10;
	localparam logic [3:0] KEY_TIMES = 4'd12;
	localparam logic [3:0] KEY_DIV   = 4'd13;

	logic clk;
	logic arst_n;

	ffc_key_if  key_ch();
	ffc_char_if disp_ch();

	four_function_calculator_entry u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.key(key_ch),
		.disp(disp_ch)
	);

	key_evt_t   key_q[$];
	disp_char_t line_q[$];
	int         errors = 0;
	int         key_gap = 0;
	int         disp_stall = 0;
	int         n_items = 0;

	// predictor state
	logic [7:0] shown [LINE_LEN];
	logic [7:0] pend_op;
	logic [4:0] prev_key;
	logic       just_eval;

	function automatic logic [7:0] op_to_char(input logic [3:0] k);
		logic [7:0] c;
		case (k)
			KEY_PLUS:  c = CH_PLUS;
			KEY_MINUS: c = CH_MINUS;
			KEY_TIMES: c = CH_TIMES;
			default:   c = CH_DIV;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] shown_at(input int p);
		return (p < LINE_LEN) ? shown[p] : 8'h00;
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [OPB-1:0] abs_val(input logic [OPB-1:0] x);
		return x[OPB-1] ? -x : x;
	endfunction

	task automatic shift_left_in(input logic [7:0] c);
		for (int i = 0; i < LINE_LEN - 1; i++) shown[i] = shown[i+1];
		shown[LINE_LEN-1] = c;
	endtask

	task automatic evaluate_line();
		int p;
		int col;
		bit neg;
		logic [OPB-1:0] a, b, r, q;
		logic [7:0] op;
		p = 0; neg = 0; a = '0; b = '0; r = '0;
		while (p < LINE_LEN && shown[p] == CH_SPACE) p++;
		if (shown_at(p) == CH_MINUS) begin
			p++;
			neg = 1;
		end
		while (is_num(shown_at(p))) begin
			a = a * 10 + OPB'(shown_at(p) - CH_ZERO);
			p++;
		end
		if (neg) a = -a;
		op = shown_at(p);
		p++;
		while (is_num(shown_at(p))) begin
			b = b * 10 + OPB'(shown_at(p) - CH_ZERO);
			p++;
		end
		if (op == CH_PLUS) r = a + b;
		else if (op == CH_MINUS) r = a - b;
		else if (op == CH_TIMES) r = a * b;
		else if (op == CH_DIV && b != 0) begin
			q = abs_val(a) / abs_val(b);
			r = (a[OPB-1] ^ b[OPB-1]) ? -q : q;
		end
		for (int i = 0; i < LINE_LEN - 1; i++) shown[i] = CH_SPACE;
		neg = r[OPB-1];
		q = abs_val(r);
		col = LINE_LEN - 1;
		if (q == 0) begin
			shown[col] = CH_ZERO;
			col--;
		end
		while (q > 0 && col >= 0) begin
			shown[col] = CH_ZERO + 8'(q % 10);
			q = q / 10;
			col--;
		end
		if (neg && col >= 0) shown[col] = CH_MINUS;
	endtask

	task automatic predict_line(input logic pressed, input logic [3:0] k);
		logic [7:0] tail;
		disp_char_t d;
		if (!pressed) begin
			prev_key = NO_KEY;
			return;
		end
		if ({1'b0, k} == prev_key) return;
		if (k < KEY_DIGIT_LIM) begin
			if (shown[0] != CH_SPACE) return;
			if (shown[LINE_LEN-7] != CH_SPACE && pend_op == CH_SPACE) return;
			if (just_eval)
				for (int i = 0; i < LINE_LEN; i++) shown[i] = CH_SPACE;
			shift_left_in(CH_ZERO + 8'(k));
		end else if (k == KEY_BKSP) begin
			if (pend_op != CH_SPACE && shown[LINE_LEN-1] == pend_op) pend_op = CH_SPACE;
			for (int i = LINE_LEN - 1; i > 0; i--) shown[i] = shown[i-1];
		end else if (k == KEY_EQUALS) begin
			if (pend_op != CH_SPACE) begin
				evaluate_line();
				pend_op = CH_SPACE;
			end
		end else begin
			tail = shown[LINE_LEN-1];
			if (tail == CH_SPACE && k == KEY_MINUS) shown[LINE_LEN-1] = CH_MINUS;
			else if (tail != pend_op && tail != CH_MINUS) begin
				if (pend_op != CH_SPACE) evaluate_line();
				pend_op = op_to_char(k);
				shift_left_in(pend_op);
			end
		end
		prev_key = {1'b0, k};
		just_eval = (k == KEY_EQUALS);
		for (int i = 0; i < LINE_LEN; i++) begin
			d.pos = 4'(i);
			d.ch = shown[i];
			d.last = (i == LINE_LEN - 1);
			line_q.push_back(d);
		end
	endtask

	task automatic push_raw(input logic pressed, input logic [3:0] k);
		key_evt_t e;
		e.pressed = pressed; e.code = k; e.drain = 0;
		key_q.push_back(e);
		n_items++;
	endtask

	// press then release, so the next press is never taken as a repeat
	task automatic tap(input logic [3:0] k);
		push_raw(1'b1, k);
		push_raw(1'b0, 4'(k ^ 4'hF));
	endtask

	task automatic tap_number(input int len);
		for (int i = 0; i < len; i++) tap(4'($urandom_range(0, 9)));
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		key_evt_t hold;
		for (int i = 0; i < LINE_LEN; i++) shown[i] = CH_SPACE;
		pend_op = CH_SPACE;
		prev_key = NO_KEY;
		just_eval = 0;

		// directed
		tap(KEY_EQUALS);
		tap(KEY_BKSP);
		for (int i = 1; i <= 9; i++) push_raw(1'b1, 4'(i));  // too-long first operand
		push_raw(1'b1, 4'd9);                                   // repeat
		tap(KEY_BKSP);
		tap(KEY_TIMES);
		tap(KEY_PLUS);                                          // op after op
		tap(4'd0);
		tap(KEY_EQUALS);
		tap(4'd7);                                              // digit after equals
		tap(KEY_DIV);
		tap(4'd0);
		tap(KEY_EQUALS);                                        // divide by zero
		tap(KEY_MINUS);
		tap(KEY_TIMES);                                         // op after minus operator
		tap(4'd5);
		tap(KEY_MINUS);
		for (int i = 0; i < 10; i++) tap(4'd9);                // long second operand
		tap(KEY_EQUALS);

		// random: mostly well-formed expressions, some noise
		while (n_items < 370) begin
			if (n_items > 180 && n_items < 200) begin
				hold.pressed = 0; hold.code = 0; hold.drain = 1;
				key_q.push_back(hold);
			end
			if ($urandom_range(0, 4) == 0) begin
				for (int i = 0; i < 4; i++) push_raw(1'($urandom), 4'($urandom));
			end else begin
				if ($urandom_range(0, 2) == 0) tap(KEY_MINUS);
				tap_number($urandom_range(1, 7));
				tap(4'($urandom_range(10, 13)));
				if ($urandom_range(0, 7) == 0) tap(4'd0);
				else tap_number($urandom_range(1, 9));
				if ($urandom_range(0, 5) == 0) tap(KEY_BKSP);
				tap($urandom_range(0, 3) == 0 ? 4'($urandom_range(10, 13)) : KEY_EQUALS);
			end
		end
	end

	initial begin
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// keypad driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_ch.valid <= 0;
			key_ch.key_pressed <= 0;
			key_ch.key_code <= '0;
		end else begin
			if (key_ch.valid && key_ch.ready)
				predict_line(key_ch.key_pressed, key_ch.key_code);
			if (!key_ch.valid || key_ch.ready) begin
				if (key_gap > 0) begin
					key_gap <= key_gap - 1;
					key_ch.valid <= 0;
				end else if (key_q.size() == 0) begin
					key_ch.valid <= 0;
				end else if (key_q[0].drain) begin
					key_ch.valid <= 0;
					if (!key_ch.valid && line_q.size() == 0) void'(key_q.pop_front());
				end else if (key_q.size() > 40 && $urandom_range(0, 5) == 0) begin
					key_gap <= $urandom_range(0, 4);
					key_ch.valid <= 0;
				end else begin
					key_ch.valid <= 1;
					key_ch.key_pressed <= key_q[0].pressed;
					key_ch.key_code <= key_q[0].code;
					void'(key_q.pop_front());
				end
			end
		end
	end

	// display monitor and checker
	always @(posedge clk or negedge arst_n) begin
		disp_char_t want;
		if (!arst_n) begin
			disp_ch.ready <= 0;
		end else begin
			if (disp_ch.valid && disp_ch.ready) begin
				if (line_q.size() == 0) begin
					$error("unexpected char transfer pos=%0d code=%h",
						disp_ch.char_position, disp_ch.char_code);
					errors++;
				end else begin
					want = line_q.pop_front();
					if (disp_ch.char_position !== want.pos) begin
						$error("char_position expected %0d got %0d", want.pos,
							disp_ch.char_position);
						errors++;
					end
					if (disp_ch.char_code !== want.ch) begin
						$error("char_code expected %h got %h", want.ch, disp_ch.char_code);
						errors++;
					end
					if (disp_ch.last_char !== want.last) begin
						$error("last_char expected %0d got %0d", want.last, disp_ch.last_char);
						errors++;
					end
				end
			end
			if (disp_stall > 0) begin
				disp_stall <= disp_stall - 1;
				disp_ch.ready <= 0;
			end else if (key_q.size() > 40 && $urandom_range(0, 7) == 0) begin
				disp_stall <= $urandom_range(0, 4);
				disp_ch.ready <= 0;
			end else begin
				disp_ch.ready <= 1;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		wait (key_q.size() == 0 && !key_ch.valid);
		wait (line_q.size() == 0);
		repeat (600) @(posedge clk);
		if (errors == 0 && line_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
